// ----- hw/rtl/rbrm_pkg.sv -----
// Shared types, register and waveform codes, and the sine table generator.
`timescale 1ns / 1ps
`default_nettype none

package rbrm_pkg;

  typedef logic signed [15:0] sample_t;   // audio sample
  typedef logic signed [16:0] mod_t;      // modulator, Q14 with headroom
  typedef logic signed [16:0] sine_t;     // sine table entry, +/-32768

  // Handoff from the modulator engine to the mixer
  typedef struct packed {
    sample_t x;
    mod_t    m;
  } mod_req_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [1:0] CFG_WAVE_SEL   = 2'd1;
  localparam logic [1:0] CFG_WET_GAIN   = 2'd2;

  // Waveform select codes; anything unlisted plays the square wave
  localparam logic [3:0] WAVE_PULSE = 4'd0;
  localparam logic [3:0] WAVE_RAMP  = 4'd1;
  localparam logic [3:0] WAVE_SINE  = 4'd2;
  localparam logic [3:0] WAVE_TRI   = 4'd3;
  localparam logic [3:0] WAVE_RECT  = 4'd4;
  localparam logic [3:0] WAVE_QSINE = 4'd5;
  localparam logic [3:0] WAVE_HSINE = 4'd6;
  localparam logic [3:0] WAVE_FSQ   = 4'd7;
  localparam logic [3:0] WAVE_FRAMP = 4'd8;

  localparam logic [15:0] PHASE_STEP_RST = 16'd682;
  localparam logic [15:0] WET_GAIN_RST   = 16'd32768;

  // Harmonic term counts, minus one
  localparam logic [3:0] FSQ_LAST  = 4'd10;
  localparam logic [3:0] FSAW_LAST = 4'd13;

  localparam logic [15:0] FSQ_COEF [11] = '{
    16'd41722, 16'd13907, 16'd8344, 16'd5960, 16'd4636, 16'd3793,
    16'd3209, 16'd2781, 16'd2454, 16'd2196, 16'd1987
  };
  localparam logic [15:0] FSAW_COEF [14] = '{
    16'd20861, 16'd10430, 16'd6954, 16'd5215, 16'd4172, 16'd3477, 16'd2980,
    16'd2608, 16'd2318, 16'd2086, 16'd1896, 16'd1738, 16'd1605, 16'd1490
  };

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Signed coefficient of term k; the saw alternates sign on even harmonics
  function automatic logic signed [17:0] coef_of(input logic is_saw,
                                                 input logic [3:0] k);
    logic [15:0] c;
    c = 16'd0;
    if (is_saw) begin
      if (k < 4'd14) c = FSAW_COEF[k];
    end else begin
      if (k < 4'd11) c = FSQ_COEF[k];
    end
    if (is_saw && k[0]) return -$signed({2'b00, c});
    return $signed({2'b00, c});
  endfunction

  // Quarter-wave Taylor evaluation, used at elaboration only
  function automatic logic [31:0] quarter_sine(input logic [31:0] k,
                                               input int unsigned qb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = ({32'd0, k} * HALF_PI_Q30) >> qb;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    t  = (((x * t) >> 30) + (64'd1 << 14)) >> 15;
    return t[31:0];
  endfunction

  function automatic sine_t rom_sine(input int unsigned idx,
                                     input int unsigned addr_bits);
    int unsigned qb;
    int unsigned qsize;
    int unsigned quad;
    int unsigned r;
    logic [31:0] v;
    qb    = addr_bits - 2;
    qsize = 1 << qb;
    quad  = (idx >> qb) & 3;
    r     = idx & (qsize - 1);
    v     = quarter_sine(32'((quad & 1) != 0 ? qsize - r : r), qb);
    if ((quad & 2) != 0) return -$signed(v[16:0]);
    return $signed(v[16:0]);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rbrm_sine_rom.sv -----
// Synchronous sine table, one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rbrm_sine_rom #(
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic [TABLE_ADDR_BITS-1:0] addr_i,
  output rbrm_pkg::sine_t                 data_o
);
  import rbrm_pkg::*;

  localparam int unsigned Depth = 1 << TABLE_ADDR_BITS;

  typedef sine_t table_t [Depth];

  function automatic table_t build_table();
    table_t tab;
    for (int unsigned i = 0; i < Depth; i++) begin
      tab[i] = rom_sine(i, TABLE_ADDR_BITS);
    end
    return tab;
  endfunction

  localparam table_t SINE_TAB = build_table();

  sine_t data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SINE_TAB[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rbrm_mod_engine.sv -----
// Modulator engine: walks harmonics through the sine table and builds the waveform.
`timescale 1ns / 1ps
`default_nettype none

module rbrm_mod_engine #(
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [3:0] wave_sel_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire rbrm_pkg::sample_t in_x_i,
  input  wire logic [15:0] in_phase_i,
  output logic            mod_valid_o,
  input  wire logic       mod_ready_i,
  output rbrm_pkg::mod_req_t mod_req_o
);
  import rbrm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]  state_q, state_d;
  sample_t     x_q;
  logic [15:0] ph_q;
  logic [15:0] hph_q;
  logic [3:0]  n_q;
  logic        v1_q, last1_q;
  logic [3:0]  k1_q;
  logic        v2_q, last2_q;
  logic signed [32:0] prod_q;
  sine_t       half_q;
  logic signed [37:0] acc_q;
  mod_t        m_q, m_d;

  logic        is_fsq, is_fsaw, issue, accept;
  logic [3:0]  last_n;
  logic [15:0] hph_step;
  sine_t       rom_data;
  logic signed [37:0] acc_rnd;
  mod_t        ph_quarter, ph_half;

  assign is_fsq   = (wave_sel_i == WAVE_FSQ);
  assign is_fsaw  = (wave_sel_i == WAVE_FRAMP);
  assign last_n   = is_fsq ? FSQ_LAST : (is_fsaw ? FSAW_LAST : 4'd0);
  assign hph_step = is_fsq ? {ph_q[14:0], 1'b0} : ph_q;  // odd harmonics only
  assign issue    = (state_q == ST_RUN);
  assign accept   = (state_q == ST_IDLE) && in_valid_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign mod_valid_o = (state_q == ST_DONE);
  assign mod_req_o   = '{x: x_q, m: m_q};

  rbrm_sine_rom #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(hph_q[15 -: TABLE_ADDR_BITS]),
    .data_o(rom_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_RUN;
      ST_RUN:  if (n_q == last_n) state_d = ST_WAIT;
      ST_WAIT: if (v2_q && last2_q) state_d = ST_CALC;
      ST_CALC: state_d = ST_DONE;
      ST_DONE: if (mod_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
    end
  end

  // Table read -> product -> accumulate
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= in_x_i;
      ph_q  <= in_phase_i;
      hph_q <= in_phase_i;
      n_q   <= 4'd0;
    end else if (issue) begin
      hph_q <= hph_q + hph_step;
      n_q   <= n_q + 4'd1;
    end
    k1_q    <= n_q;
    last1_q <= issue && (n_q == last_n);
    last2_q <= last1_q;
    prod_q  <= 33'(coef_of(is_fsaw, k1_q)) * 33'(rom_data);
    if (v1_q && (k1_q == 4'd0)) half_q <= (rom_data + 17'sd2) >>> 2;
    if (accept) acc_q <= '0;
    else if (v2_q) acc_q <= acc_q + 38'(prod_q);
    if (state_q == ST_CALC) m_q <= m_d;
  end

  assign acc_rnd    = (acc_q + (38'sd1 <<< 16)) >>> 17;
  assign ph_quarter = $signed({3'b000, ph_q[15:2]});
  assign ph_half    = $signed({2'b00, ph_q[15:1]});

  always_comb begin
    unique case (wave_sel_i)
      WAVE_RAMP:  m_d = ph_quarter - 17'sd8192;
      WAVE_SINE:  m_d = half_q;
      WAVE_TRI:   m_d = (ph_q > 16'd32768) ? 17'sd24576 - ph_half
                                           : ph_half - 17'sd8192;
      WAVE_RECT:  m_d = (ph_q[15] ? -half_q : half_q) - 17'sd8192;
      WAVE_QSINE: m_d = ((ph_q < 16'd16384) ? half_q : 17'sd0) - 17'sd8192;
      WAVE_HSINE: m_d = (ph_q[15] ? 17'sd0 : half_q) - 17'sd8192;
      WAVE_FSQ,
      WAVE_FRAMP: m_d = acc_rnd[16:0];
      default:    m_d = (ph_q > 16'd32768) ? 17'sd8192 : -17'sd8192;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rbrm_mixer.sv -----
// Wet/dry mixer with rounding, saturation and the output register.
`timescale 1ns / 1ps
`default_nettype none

module rbrm_mixer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] wet_gain_i,
  input  wire logic        mod_valid_i,
  output logic             mod_ready_o,
  input  wire rbrm_pkg::mod_req_t mod_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rbrm_pkg::sample_t out_sample_o
);
  import rbrm_pkg::*;

  logic        v1_q, v2_q, out_valid_q;
  sample_t     x1_q, x2_q, out_q;
  logic signed [32:0] p1_q;
  logic signed [17:0] md_q;
  logic signed [50:0] p2_q;
  logic signed [51:0] sum;
  logic signed [22:0] r;
  sample_t     sat;
  logic        out_free, start, fire;

  assign mod_ready_o = !v1_q && !v2_q;
  assign start       = mod_valid_i && mod_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = v2_q && out_free;

  // out = round((x*2^29 + x*wet*(m - 8192)) / 2^29)
  assign sum = (52'(x2_q) <<< 29) + 52'(p2_q) + (52'sd1 <<< 28);
  assign r   = 23'(sum >>> 29);

  always_comb begin
    if (r > 23'sd32767)       sat = 16'sh7fff;
    else if (r < -23'sd32768) sat = 16'sh8000;
    else                      sat = r[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= start;
      if (v1_q) v2_q <= 1'b1;
      else if (fire) v2_q <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      x1_q <= mod_req_i.x;
      p1_q <= 33'(mod_req_i.x) * 33'($signed({1'b0, wet_gain_i}));
      md_q <= 18'(mod_req_i.m) - 18'sd8192;
    end
    if (v1_q) begin
      x2_q <= x1_q;
      p2_q <= 51'(p1_q) * 51'(md_q);
    end
    if (fire) out_q <= sat;
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/robotize_ring_modulator_core.sv -----
// Ring modulator top level: configuration registers, phase accumulator and datapath.
//
// One signed 16-bit sample enters on the s_axis stream and one modulated,
// wet/dry mixed and saturated sample leaves on the m_axis stream for each.
// The modulator phase advances by phase_step with every accepted sample.
// Registers are written over the cfg port (index 0 phase_step, 1 waveform
// select, 2 wet gain); the user must write them only while no sample is in
// flight, as the block does not enforce it. cfg_ready_o is always high.
// The modulator engine reads the sine table once per harmonic, one read per
// cycle on its single port, and takes a new sample only once it has handed
// its result to the mixer; the mixer behind it runs in parallel with the next
// sample's harmonics.
// The output register holds a finished result while m_axis_tready is low;
// a following sample is still taken and waits in the mixer once it is done.
// Reset clears the phase to zero, restores the register defaults and empties
// every stage. The sine table is a constant and needs no fill after reset.
`timescale 1ns / 1ps
`default_nettype none

module robotize_ring_modulator_core #(
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] in_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] out_sample
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import rbrm_pkg::*;

  logic [15:0] phase_step_q, wet_gain_q, phase_q;
  logic [3:0]  wave_sel_q;
  logic        in_accept, mod_valid, mod_ready;
  mod_req_t    mod_req;
  sample_t     out_sample;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      wave_sel_q   <= WAVE_PULSE;
      wet_gain_q   <= WET_GAIN_RST;
      phase_q      <= 16'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
          CFG_WAVE_SEL:   wave_sel_q   <= cfg_data_i[3:0];
          CFG_WET_GAIN:   wet_gain_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_accept) phase_q <= phase_q + phase_step_q;
    end
  end

  rbrm_mod_engine #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wave_sel_i (wave_sel_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_x_i     ($signed(s_axis_tdata)),
    .in_phase_i (phase_q),
    .mod_valid_o(mod_valid),
    .mod_ready_i(mod_ready),
    .mod_req_o  (mod_req)
  );

  rbrm_mixer u_mixer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wet_gain_i  (wet_gain_q),
    .mod_valid_i (mod_valid),
    .mod_ready_o (mod_ready),
    .mod_req_i   (mod_req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sample_o(out_sample)
  );

  assign m_axis_tdata = out_sample;

endmodule

`default_nettype wire
